// ===== design/assert_macros.svh =====
// concurrent assertion helpers, removed for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define CCS_ASSERT_NOW(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define CCS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define CCS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CCS_ASSERT_NOW(name, clk, rst, cond)
`define CCS_ASSERT_IMP(name, clk, rst, ante, cons)
`define CCS_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== design/ccs_pkg.sv =====
package ccs_pkg;

   localparam int LINE_BITS   = 32;
   localparam int BCD_DIGITS  = 10;
   localparam int DIGIT_BITS  = $clog2(BCD_DIGITS + 1);
   localparam int SEQ_BITS    = 5;
   localparam int MARK_PREFIX = 7;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_VT    = 8'h0b;
   localparam logic [7:0] CH_FF    = 8'h0c;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_EXCL  = 8'h21;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_QM    = 8'h3f;
   localparam logic [7:0] CH_LBRK  = 8'h5b;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_RBRK  = 8'h5d;
   localparam logic [7:0] CH_LC_E  = 8'h65;
   localparam logic [7:0] CH_LC_I  = 8'h69;
   localparam logic [7:0] CH_LC_L  = 8'h6c;
   localparam logic [7:0] CH_LC_N  = 8'h6e;
   localparam logic [7:0] CH_LBRC  = 8'h7b;
   localparam logic [7:0] CH_BAR   = 8'h7c;
   localparam logic [7:0] CH_RBRC  = 8'h7d;

   typedef enum logic [9:0] {
      MODE_NORMAL = 10'b00_0000_0001,
      MODE_BACKSL = 10'b00_0000_0010,
      MODE_SPACE  = 10'b00_0000_0100,
      MODE_SLASH  = 10'b00_0000_1000,
      MODE_LINEC  = 10'b00_0001_0000,
      MODE_BLOCK  = 10'b00_0010_0000,
      MODE_BSTAR  = 10'b00_0100_0000,
      MODE_QUOTE  = 10'b00_1000_0000,
      MODE_QESC   = 10'b01_0000_0000,
      MODE_PASS   = 10'b10_0000_0000
   } mode_type;

   typedef logic [BCD_DIGITS-1:0][3:0] bcd_type;

   // output burst for one input item: optional space, line sync, up to two bytes
   typedef struct packed {
      logic                      pre_en;
      logic [SEQ_BITS-1:0]       sync_len;
      logic                      sync_mark;
      bcd_type                   mark_bcd;
      logic [DIGIT_BITS-1:0]     mark_digits;
      logic [1:0][7:0]           post_byte;
      logic [SEQ_BITS-1:0]       total;
   } job_type;

   // "\n#line " prefix of a line marker
   function automatic logic [7:0] mark_prefix(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = CH_NL;
         3'd1:    ch = CH_HASH;
         3'd2:    ch = CH_LC_L;
         3'd3:    ch = CH_LC_I;
         3'd4:    ch = CH_LC_N;
         3'd5:    ch = CH_LC_E;
         default: ch = CH_SP;
      endcase
      return ch;
   endfunction

endpackage

// ===== design/c_comment_stripper.sv =====
// channel   direction  payload                              transfer when
// req_      in         source_byte[8], end_of_input[1]      req_valid && req_ready
// rsp_      out        out_byte[8], last[1]                 rsp_valid && rsp_ready
//
// each accepted byte is scanned in the cycle it is taken; scanner state updates
// at once and the bytes it causes go to a burst register
// the burst drains one byte per cycle into the output register while that register is free,
// so an item with n result bytes occupies the burst register until all n have moved on (n is 0 to 20)
// a new item is taken in the cycle the previous burst hands over its last byte, giving one
// item per cycle for ordinary text while rsp_ready holds; line syncs stall the input briefly
// an item's result bytes pass through the burst register and then the output register
// reset is synchronous and returns the scanner to line one, normal text mode

`include "assert_macros.svh"

module c_comment_stripper import ccs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_source_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   // scanner state
   mode_type               mode_ff, mode_in;
   logic [7:0]             prev_ff, prev_in;
   logic                   quote_ff, quote_in;
   logic                   have_data_ff, have_data_in;
   logic                   formals_ff, formals_in;
   logic [LINE_BITS-1:0]   line_count_ff, line_count_in;
   bcd_type                line_bcd_ff, line_bcd_in;
   logic [LINE_BITS-1:0]   synced_ff, synced_in;
   logic [LINE_BITS-1:0]   directive_ff, directive_in;

   // burst and output registers
   job_type                job_ff, job_in;
   logic                   job_valid_ff;
   logic [SEQ_BITS-1:0]    job_idx_ff;
   logic [7:0]             rsp_byte_ff;
   logic                   rsp_last_ff;
   logic                   rsp_valid_ff;

   // line counter helpers
   logic [LINE_BITS-1:0]   line_next;
   logic [LINE_BITS-1:0]   dir_next;
   bcd_type                bcd_next;
   logic [DIGIT_BITS-1:0]  digits;
   logic [LINE_BITS-1:0]   line_gap;
   logic                   sync_cond;
   logic                   use_mark;
   logic [SEQ_BITS-1:0]    sync_len_now;
   logic                   dir_eq;

   logic                   out_free;
   logic                   job_adv;
   logic                   job_end;
   logic                   accept;
   logic [7:0]             cur_byte;

   // saturating line counters, decimal copy stops with the binary one
   always_comb begin : line_calc
      logic carry;
      carry     = 1'b1;
      bcd_next  = line_bcd_ff;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (carry) begin
            if (line_bcd_ff[i] < 4'd9) begin
               bcd_next[i] = line_bcd_ff[i] + 4'd1;
               carry       = 1'b0;
            end else begin
               bcd_next[i] = 4'd0;
            end
         end
      end
      if (&line_count_ff) begin
         bcd_next = line_bcd_ff;
      end
      line_next = (&line_count_ff) ? line_count_ff : line_count_ff + 1'b1;
      dir_next  = (&directive_ff) ? directive_ff : directive_ff + 1'b1;
      // number of decimal digits in the current line number
      digits = DIGIT_BITS'(1);
      for (int i = 1; i < BCD_DIGITS; i++) begin
         if (line_bcd_ff[i] != 4'd0) begin
            digits = DIGIT_BITS'(i + 1);
         end
      end
   end

   // pending newlines either as blank lines or as a line marker, whichever is shorter, the marker on a tie
   assign line_gap  = line_count_ff - synced_ff;
   assign sync_cond = (line_count_ff > synced_ff) && (line_count_ff > directive_ff);
   assign use_mark  = (LINE_BITS'(digits) + LINE_BITS'(MARK_PREFIX + 1)) <= line_gap;
   assign sync_len_now = use_mark ? SEQ_BITS'(MARK_PREFIX + 1) + SEQ_BITS'(digits)
                                  : line_gap[SEQ_BITS-1:0];
   assign dir_eq = (directive_ff == line_count_ff);

   // one scan step
   always_comb begin : scan_step
      logic [7:0]      b;
      logic            do_pn;
      logic [7:0]      pn_c;
      logic            sync_req;
      logic            inc_line;
      logic            inc_dir;
      logic            sync_to_new;
      logic            go_space;
      logic [1:0]      post_cnt;
      logic [1:0][7:0] post_b;
      logic            pre_en;

      b           = req_source_byte;
      do_pn       = 1'b0;
      pn_c        = b;
      sync_req    = 1'b0;
      inc_line    = 1'b0;
      inc_dir     = 1'b0;
      sync_to_new = 1'b0;
      go_space    = 1'b0;
      post_cnt    = 2'd0;
      post_b      = '0;
      pre_en      = 1'b0;

      mode_in       = mode_ff;
      prev_in       = prev_ff;
      quote_in      = quote_ff;
      have_data_in  = have_data_ff;
      formals_in    = formals_ff;
      line_count_in = line_count_ff;
      line_bcd_in   = line_bcd_ff;
      synced_in     = synced_ff;
      directive_in  = directive_ff;

      if (req_end_of_input) begin
         if (mode_ff == MODE_SPACE) begin
            post_b[post_cnt[0]] = CH_SP;
            post_cnt = post_cnt + 2'd1;
         end
         if ((mode_ff == MODE_NORMAL || mode_ff == MODE_SPACE) &&
             line_count_ff != synced_ff) begin
            post_b[post_cnt[0]] = CH_NL;
            post_cnt = post_cnt + 2'd1;
         end
      end else begin
         case (mode_ff)
            MODE_BACKSL: begin
               mode_in = MODE_NORMAL;
               if (b == CH_NL) begin
                  inc_dir     = 1'b1;
                  inc_line    = 1'b1;
                  sync_to_new = 1'b1;
                  prev_in     = CH_NUL;
               end else begin
                  prev_in = b;
               end
               post_b[post_cnt[0]] = b;
               post_cnt = post_cnt + 2'd1;
            end
            MODE_SPACE: begin
               // decide if the held space is needed between its neighbors
               if (b inside {CH_NL, CH_RPAR, CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC, CH_SEMI,
                             CH_COLON, CH_EQ, CH_EXCL, CH_LT, CH_GT, CH_BAR, CH_COMMA,
                             CH_QM}) begin
                  pre_en = 1'b0;
               end else if (b == CH_LPAR) begin
                  if (dir_eq && formals_ff) begin
                     formals_in = 1'b0;
                     pre_en     = 1'b1;
                  end
               end else if (b == CH_STAR) begin
                  pre_en = (prev_ff == CH_SLASH) || (prev_ff == CH_EQ);
               end else if (b inside {CH_PLUS, CH_MINUS, CH_AMP}) begin
                  pre_en = (prev_ff == b) || (prev_ff == CH_EQ);
               end else begin
                  pre_en = 1'b1;
               end
               prev_in = CH_SP;
               mode_in = MODE_NORMAL;
               do_pn   = 1'b1;
            end
            MODE_SLASH: begin
               if (b == CH_SLASH) begin
                  mode_in = MODE_LINEC;
                  prev_in = CH_SLASH;
               end else if (b == CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end else begin
                  mode_in      = MODE_NORMAL;
                  sync_req     = 1'b1;
                  have_data_in = 1'b1;
                  post_b[post_cnt[0]] = CH_SLASH;
                  post_cnt = post_cnt + 2'd1;
                  prev_in = CH_SLASH;
                  do_pn   = 1'b1;
               end
            end
            MODE_LINEC: begin
               if (b == CH_NL) begin
                  if (prev_ff == CH_BSL) begin
                     post_b[0]   = CH_BSL;
                     post_b[1]   = CH_NL;
                     post_cnt    = 2'd2;
                     inc_line    = 1'b1;
                     sync_to_new = 1'b1;
                     prev_in     = CH_NL;
                  end else begin
                     mode_in = MODE_NORMAL;
                     prev_in = CH_SP;
                     do_pn   = 1'b1;
                  end
               end else begin
                  prev_in = b;
               end
            end
            MODE_BLOCK: begin
               if (b == CH_NL) begin
                  inc_dir  = 1'b1;
                  inc_line = 1'b1;
               end else if (b == CH_STAR) begin
                  mode_in = MODE_BSTAR;
               end
            end
            MODE_BSTAR: begin
               if (b == CH_NL) begin
                  inc_dir  = 1'b1;
                  inc_line = 1'b1;
                  mode_in  = MODE_BLOCK;
               end else if (b == CH_SLASH) begin
                  mode_in = MODE_NORMAL;
                  prev_in = CH_SP;
               end else if (b != CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end
            end
            MODE_QUOTE: begin
               if (b == CH_BSL) begin
                  post_b[post_cnt[0]] = b;
                  post_cnt = post_cnt + 2'd1;
                  mode_in  = MODE_QESC;
               end else if (b == (quote_ff ? CH_SQ : CH_DQ)) begin
                  post_b[post_cnt[0]] = b;
                  post_cnt = post_cnt + 2'd1;
                  mode_in  = MODE_NORMAL;
                  prev_in  = b;
               end else if (b == CH_NL) begin
                  // unterminated literal ends at the newline
                  mode_in = MODE_NORMAL;
                  prev_in = CH_SP;
                  do_pn   = 1'b1;
               end else begin
                  post_b[post_cnt[0]] = b;
                  post_cnt = post_cnt + 2'd1;
               end
            end
            MODE_QESC: begin
               if (b == CH_NL) begin
                  inc_dir     = 1'b1;
                  inc_line    = 1'b1;
                  sync_to_new = 1'b1;
               end
               post_b[post_cnt[0]] = b;
               post_cnt = post_cnt + 2'd1;
               mode_in  = MODE_QUOTE;
            end
            MODE_PASS: begin
               post_b[post_cnt[0]] = b;
               post_cnt = post_cnt + 2'd1;
            end
            default: begin
               mode_in = MODE_NORMAL;
               do_pn   = 1'b1;
            end
         endcase

         // normal text handling of one byte
         if (do_pn) begin
            if (pn_c == CH_NUL) begin
               post_b[post_cnt[0]] = CH_NUL;
               post_cnt = post_cnt + 2'd1;
               mode_in  = MODE_PASS;
            end else if (pn_c == CH_BSL) begin
               sync_req     = 1'b1;
               have_data_in = 1'b1;
               post_b[post_cnt[0]] = pn_c;
               post_cnt = post_cnt + 2'd1;
               mode_in  = MODE_BACKSL;
            end else if (pn_c inside {CH_FF, CH_TAB, CH_VT, CH_SP}) begin
               if (have_data_in) begin
                  if (prev_in == CH_RPAR) begin
                     // keep one space between a macro's formals and its body
                     if (dir_eq && formals_in) begin
                        formals_in = 1'b0;
                        post_b[post_cnt[0]] = CH_SP;
                        post_cnt = post_cnt + 2'd1;
                     end
                  end else if (!(prev_in inside {CH_SP, CH_NL, CH_LPAR, CH_LBRK, CH_RBRK,
                                                 CH_LBRC, CH_RBRC, CH_SEMI, CH_COLON,
                                                 CH_EXCL, CH_LT, CH_GT, CH_BAR, CH_COMMA,
                                                 CH_QM, CH_STAR})) begin
                     go_space = 1'b1;
                  end
               end
               if (go_space) begin
                  mode_in = MODE_SPACE;
               end else begin
                  prev_in = CH_SP;
               end
            end else if (pn_c == CH_NL) begin
               have_data_in = 1'b0;
               inc_line     = 1'b1;
               prev_in      = CH_NL;
            end else if (pn_c == CH_HASH) begin
               sync_req     = 1'b1;
               directive_in = line_count_ff;
               formals_in   = 1'b1;
               have_data_in = 1'b1;
               post_b[post_cnt[0]] = CH_HASH;
               post_cnt = post_cnt + 2'd1;
               prev_in  = CH_HASH;
            end else if (pn_c == CH_SLASH) begin
               mode_in = MODE_SLASH;
               prev_in = CH_SLASH;
            end else if (pn_c inside {CH_DQ, CH_SQ}) begin
               sync_req     = 1'b1;
               have_data_in = 1'b1;
               post_b[post_cnt[0]] = pn_c;
               post_cnt = post_cnt + 2'd1;
               quote_in = (pn_c == CH_SQ);
               mode_in  = MODE_QUOTE;
            end else begin
               sync_req     = 1'b1;
               have_data_in = 1'b1;
               post_b[post_cnt[0]] = pn_c;
               post_cnt = post_cnt + 2'd1;
               prev_in  = pn_c;
            end
         end

         if (sync_req && sync_cond) begin
            synced_in = line_count_ff;
         end
         if (inc_dir) begin
            directive_in = dir_next;
         end
         if (inc_line) begin
            line_count_in = line_next;
            line_bcd_in   = bcd_next;
         end
         if (sync_to_new) begin
            synced_in = line_next;
         end
      end

      job_in.pre_en      = pre_en;
      job_in.sync_len    = (sync_req && sync_cond) ? sync_len_now : '0;
      job_in.sync_mark   = use_mark;
      job_in.mark_bcd    = line_bcd_ff;
      job_in.mark_digits = digits;
      job_in.post_byte   = post_b;
      job_in.total       = SEQ_BITS'(pre_en) + job_in.sync_len + SEQ_BITS'(post_cnt);

      // end of file puts the scanner state back to the reset state
      if (req_end_of_input) begin
         mode_in       = MODE_NORMAL;
         prev_in       = CH_NUL;
         quote_in      = 1'b0;
         have_data_in  = 1'b0;
         formals_in    = 1'b0;
         line_count_in = '0;
         line_bcd_in   = bcd_type'(1);
         synced_in     = '0;
         directive_in  = '0;
      end
   end

   // byte at the current position of the burst
   always_comb begin : burst_byte
      logic [SEQ_BITS-1:0]   j;
      logic [SEQ_BITS-1:0]   k;
      logic [SEQ_BITS-1:0]   didx;
      logic [3:0]            nib;
      j    = job_idx_ff - SEQ_BITS'(job_ff.pre_en);
      k    = j - job_ff.sync_len;
      didx = SEQ_BITS'(job_ff.mark_digits) + SEQ_BITS'(MARK_PREFIX - 1) - j;
      nib  = 4'd0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (didx == SEQ_BITS'(i)) begin
            nib = job_ff.mark_bcd[i];
         end
      end
      if (job_ff.pre_en && job_idx_ff == '0) begin
         cur_byte = CH_SP;
      end else if (j < job_ff.sync_len) begin
         if (!job_ff.sync_mark) begin
            cur_byte = CH_NL;
         end else if (j < SEQ_BITS'(MARK_PREFIX)) begin
            cur_byte = mark_prefix(j[2:0]);
         end else if (j < SEQ_BITS'(MARK_PREFIX) + SEQ_BITS'(job_ff.mark_digits)) begin
            cur_byte = CH_ZERO + {4'd0, nib};
         end else begin
            cur_byte = CH_NL;
         end
      end else begin
         cur_byte = job_ff.post_byte[k[0]];
      end
   end

   // burst drains when the output register is empty or being taken
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign job_adv   = job_valid_ff && out_free;
   assign job_end   = job_idx_ff == (job_ff.total - 1'b1);
   assign req_ready = !job_valid_ff || (job_adv && job_end);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NORMAL;
         prev_ff       <= CH_NUL;
         quote_ff      <= 1'b0;
         have_data_ff  <= 1'b0;
         formals_ff    <= 1'b0;
         line_count_ff <= '0;
         line_bcd_ff   <= bcd_type'(1);
         synced_ff     <= '0;
         directive_ff  <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         prev_ff       <= prev_in;
         quote_ff      <= quote_in;
         have_data_ff  <= have_data_in;
         formals_ff    <= formals_in;
         line_count_ff <= line_count_in;
         line_bcd_ff   <= line_bcd_in;
         synced_ff     <= synced_in;
         directive_ff  <= directive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         job_idx_ff   <= '0;
      end else if (accept) begin
         // items with no output never occupy the burst register
         job_valid_ff <= job_in.total != '0;
         job_idx_ff   <= '0;
      end else if (job_adv && job_end) begin
         job_valid_ff <= 1'b0;
      end else if (job_adv) begin
         job_idx_ff <= job_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (job_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_adv) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= job_end;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // synced line never runs ahead of the line counter
   `CCS_ASSERT_NOW(a_sync_behind, clock, reset, synced_ff <= line_count_ff)
   // burst position stays inside the burst
   `CCS_ASSERT_IMP(a_idx_range, clock, reset, job_valid_ff, job_idx_ff < job_ff.total)
   // a pending burst with room downstream always yields a result next cycle
   `CCS_ASSERT_NXT(a_burst_moves, clock, reset, job_adv, rsp_valid_ff)

endmodule

// ===== tb/c_comment_stripper_test.sv =====
`timescale 1ns / 100ps

module c_comment_stripper_test;
   import ccs_pkg::*;

   // one source transfer and one stripped output byte
   typedef struct {
      logic [7:0] src;
      logic       eof;
   } src_item_type;

   typedef struct {
      logic [7:0] text;
      logic       last;
   } out_item_type;

   // scanner modes of the predictor
   typedef enum int {
      SC_NORMAL, SC_BACKSL, SC_SPACE, SC_SLASH, SC_LINEC,
      SC_BLOCK, SC_BSTAR, SC_QUOTE, SC_QESC, SC_PASS
   } scan_type;

   localparam int  NUM_PHASES  = 4;
   localparam int  RANDOM_ITEMS = 480;
   localparam int  CYCLE_LIMIT = 600000;
   localparam int  DRAIN_CYCLES = 30;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_source_byte = 8'h00;
   logic       req_end_of_input = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   c_comment_stripper uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_source_byte  (req_source_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last)
   );

   src_item_type pending_src[$];
   out_item_type stripped_text[$];
   logic [7:0] burst[$];

   int total_items;
   int items_taken;
   int bytes_seen;
   int mismatches;
   int cycles;
   int files_ended;

   // predictor state
   scan_type    sc_mode;
   logic [7:0]  sc_prev;
   logic        sc_single;
   logic        sc_have_data;
   logic        sc_formals;
   logic [31:0] sc_lines;
   logic [39:0] sc_bcd;
   logic [31:0] sc_synced;
   logic [31:0] sc_dir_line;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic scanner_reset();
      sc_mode = SC_NORMAL;
      sc_prev = 8'h00;
      sc_single = 1'b0;
      sc_have_data = 1'b0;
      sc_formals = 1'b0;
      sc_lines = '0;
      sc_bcd = 40'h1;
      sc_synced = '0;
      sc_dir_line = '0;
   endtask

   task automatic put(input logic [7:0] b);
      if (burst.size() < 32) begin
         burst.push_back(b);
      end
   endtask

   function automatic bit one_of(input logic [7:0] c, input string s);
      for (int i = 0; i < s.len(); i++) begin
         if (s[i] == c) return 1'b1;
      end
      return 1'b0;
   endfunction

   // line counter and its bcd image, both stop at the top
   task automatic next_line();
      logic [3:0] d;
      if (sc_lines == '1) return;
      sc_lines++;
      for (int i = 0; i < 10; i++) begin
         d = sc_bcd[4*i +: 4];
         sc_bcd[4*i +: 4] = 4'h0;
         if (d < 4'd9) begin
            sc_bcd[4*i +: 4] = d + 4'd1;
            return;
         end
      end
   endtask

   // restore held-back newlines as blank lines or a line marker
   task automatic catch_up_lines();
      int digits;
      string head;
      digits = 1;
      head = "\n#line ";
      if (!(sc_lines > sc_synced && sc_lines > sc_dir_line)) return;
      for (int i = 9; i > 0; i--) begin
         if (sc_bcd[4*i +: 4] != 4'h0) begin
            digits = i + 1;
            break;
         end
      end
      if (32'(8 + digits) <= sc_lines - sc_synced) begin
         for (int i = 0; i < head.len(); i++) put(head[i]);
         for (int i = digits - 1; i >= 0; i--) put(CH_ZERO + 8'(sc_bcd[4*i +: 4]));
         put(CH_NL);
         sc_synced = sc_lines;
      end else begin
         while (sc_synced < sc_lines) begin
            sc_synced++;
            put(CH_NL);
         end
      end
      sc_have_data = 1'b0;
   endtask

   task automatic put_data(input logic [7:0] c);
      catch_up_lines();
      sc_have_data = 1'b1;
      put(c);
   endtask

   task automatic plain_char(input logic [7:0] c);
      case (c)
         CH_NUL: begin
            put(CH_NUL);
            sc_mode = SC_PASS;
         end
         CH_BSL: begin
            put_data(c);
            sc_mode = SC_BACKSL;
         end
         CH_FF, CH_TAB, CH_VT, CH_SP: begin
            if (sc_have_data) begin
               if (sc_prev == CH_RPAR) begin
                  if (sc_dir_line == sc_lines && sc_formals) begin
                     sc_formals = 1'b0;
                     put(CH_SP);
                  end
               end else if (!one_of(sc_prev, " \n([]{};:!<>|,?*")) begin
                  // hold the space until the next byte decides it
                  sc_mode = SC_SPACE;
                  return;
               end
            end
            sc_prev = CH_SP;
         end
         CH_NL: begin
            sc_have_data = 1'b0;
            next_line();
            sc_prev = CH_NL;
         end
         CH_HASH: begin
            catch_up_lines();
            sc_dir_line = sc_lines;
            sc_formals = 1'b1;
            put_data(CH_HASH);
            sc_prev = CH_HASH;
         end
         CH_SLASH: begin
            sc_mode = SC_SLASH;
            sc_prev = CH_SLASH;
         end
         CH_DQ, CH_SQ: begin
            put_data(c);
            sc_single = (c == CH_SQ);
            sc_mode = SC_QUOTE;
         end
         default: begin
            put_data(c);
            sc_prev = c;
         end
      endcase
   endtask

   // decide the held space from its two neighbours
   task automatic settle_space(input logic [7:0] p, input logic [7:0] n);
      if (one_of(n, "\n)[]{};:=!<>|,?")) return;
      if (n == CH_LPAR) begin
         if (sc_dir_line == sc_lines && sc_formals) begin
            sc_formals = 1'b0;
            put(CH_SP);
         end
      end else if (n == CH_STAR) begin
         if (p == CH_SLASH || p == CH_EQ) put(CH_SP);
      end else if (n == CH_PLUS || n == CH_MINUS || n == CH_AMP) begin
         if (p == n || p == CH_EQ) put(CH_SP);
      end else begin
         put(CH_SP);
      end
   endtask

   task automatic strip_byte(input src_item_type it);
      logic [7:0] b;
      int n;
      b = it.src;
      burst.delete();
      if (it.eof) begin
         if (sc_mode == SC_SPACE) put(CH_SP);
         if ((sc_mode == SC_NORMAL || sc_mode == SC_SPACE) && sc_lines != sc_synced)
            put(CH_NL);
         scanner_reset();
      end else begin
         case (sc_mode)
            SC_BACKSL: begin
               sc_mode = SC_NORMAL;
               if (b == CH_NL) begin
                  if (sc_dir_line != '1) sc_dir_line++;
                  next_line();
                  sc_synced = sc_lines;
                  put(CH_NL);
                  sc_prev = 8'h00;
               end else begin
                  put(b);
                  sc_prev = b;
               end
            end
            SC_SPACE: begin
               sc_mode = SC_NORMAL;
               settle_space(sc_prev, b);
               sc_prev = CH_SP;
               plain_char(b);
            end
            SC_SLASH: begin
               if (b == CH_SLASH) begin
                  sc_mode = SC_LINEC;
                  sc_prev = CH_SLASH;
               end else if (b == CH_STAR) begin
                  sc_mode = SC_BLOCK;
               end else begin
                  sc_mode = SC_NORMAL;
                  put_data(CH_SLASH);
                  sc_prev = CH_SLASH;
                  plain_char(b);
               end
            end
            SC_LINEC: begin
               if (b == CH_NL) begin
                  if (sc_prev == CH_BSL) begin
                     // continued line comment keeps its backslash-newline
                     put(CH_BSL);
                     put(CH_NL);
                     next_line();
                     sc_synced = sc_lines;
                     sc_prev = CH_NL;
                  end else begin
                     sc_mode = SC_NORMAL;
                     sc_prev = CH_SP;
                     plain_char(CH_NL);
                  end
               end else begin
                  sc_prev = b;
               end
            end
            SC_BLOCK: begin
               if (b == CH_NL) begin
                  if (sc_dir_line != '1) sc_dir_line++;
                  next_line();
               end else if (b == CH_STAR) begin
                  sc_mode = SC_BSTAR;
               end
            end
            SC_BSTAR: begin
               if (b == CH_NL) begin
                  if (sc_dir_line != '1) sc_dir_line++;
                  next_line();
                  sc_mode = SC_BLOCK;
               end else if (b == CH_SLASH) begin
                  sc_mode = SC_NORMAL;
                  sc_prev = CH_SP;
               end else if (b != CH_STAR) begin
                  sc_mode = SC_BLOCK;
               end
            end
            SC_QUOTE: begin
               if (b == CH_BSL) begin
                  put(b);
                  sc_mode = SC_QESC;
               end else if (b == (sc_single ? CH_SQ : CH_DQ)) begin
                  put(b);
                  sc_mode = SC_NORMAL;
                  sc_prev = b;
               end else if (b == CH_NL) begin
                  sc_mode = SC_NORMAL;
                  sc_prev = CH_SP;
                  plain_char(CH_NL);
               end else begin
                  put(b);
               end
            end
            SC_QESC: begin
               if (b == CH_NL) begin
                  if (sc_dir_line != '1) sc_dir_line++;
                  next_line();
                  sc_synced = sc_lines;
               end
               put(b);
               sc_mode = SC_QUOTE;
            end
            SC_PASS: put(b);
            default: begin
               sc_mode = SC_NORMAL;
               plain_char(b);
            end
         endcase
      end
      n = (burst.size() > 24) ? 24 : burst.size();
      for (int k = 0; k < n; k++) begin
         stripped_text.push_back('{text: burst[k], last: (k == n - 1)});
      end
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         pending_src.push_back('{src: s[i], eof: 1'b0});
      end
      total_items += s.len();
   endtask

   task automatic add_byte(input logic [7:0] b);
      pending_src.push_back('{src: b, eof: 1'b0});
      total_items++;
   endtask

   task automatic add_eof();
      pending_src.push_back('{src: 8'($urandom_range(0, 255)), eof: 1'b1});
      total_items++;
   endtask

   // a random fragment of c-like text, mostly well formed
   task automatic add_fragment();
      int pick;
      pick = $urandom_range(0, 19);
      case (pick)
         0:  add_text("int x = a+ +b;\n");
         1:  add_text("p = q - -r & &s *t;\n");
         2:  add_text("/* block\n ** comment */ y\t=\v1;\n");
         3:  add_text("// line comment \\\n carried on\nz;\n");
         4:  add_text("s = \"str\\\"in\\\ng\" ;\n");
         5:  add_text("c = '\\n' ; d='x';\n");
         6:  add_text("#define f (a) ((a) +1)\n");
         7:  add_text("#  define g(b) b\n");
         8:  add_text("a \\\nb\f c\n");
         9:  add_text("\n\n\n\n\n\n\n\n\n\n\n\n\nw\n");
         10: add_text("x = y / z; u = v /*k*/ *w;\n");
         11: add_text("if (a) { b [1] ; } else c ? d : e , f ! g | h < i > j\n");
         12: add_text("x =*p; y = &q; \"open\n");
         13: add_text("r = 'a\nq\t\t \t*= 2;\n");
         14: add_text("/* ** / * */ /");
         15: begin
            if ($urandom_range(0, 3) == 0) add_eof();
            else add_text("\n\n");
         end
         16: begin
            // pass-through stretch, closed by end of file
            add_byte(CH_NUL);
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            add_eof();
         end
         default: begin
            // noise: any byte but nul, which would lock into pass-through
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(1, 255)));
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatches++;
      $display("mismatch at output byte %0d: %s got %02h expected %02h",
               bytes_seen, what, got, want);
   endtask

   function automatic int idle_phase(input int n);
      return (total_items == 0) ? 0 : (n * NUM_PHASES) / total_items;
   endfunction

   // driver: holds valid and payload until the transfer happens
   always @(posedge clock) begin
      logic          hold;
      logic          nxt_valid;
      int            ph;
      src_item_type  it;
      hold = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            strip_byte('{src: req_source_byte, eof: req_end_of_input});
            items_taken++;
            if (req_end_of_input) files_ended++;
         end
         hold = req_valid && !req_ready;
         nxt_valid = hold;
         ph = idle_phase(items_taken);
         if (!hold && pending_src.size() != 0) begin
            // sender idles 88 of 100 in phase one, 7 of 100 in phase three
            if (!((ph == 1 && $urandom_range(0, 99) < 88) ||
                  (ph == 3 && $urandom_range(0, 99) < 7))) begin
               it = pending_src.pop_front();
               req_source_byte <= it.src;
               req_end_of_input <= it.eof;
               nxt_valid = 1'b1;
            end
         end
         req_valid <= nxt_valid;
         // receiver stalls 88 of 100 in phase two, 7 of 100 in phase three
         rsp_ready <= !((ph == 2 && $urandom_range(0, 99) < 88) ||
                        (ph == 3 && $urandom_range(0, 99) < 7));
      end
   end

   // monitor: each output transfer against the oldest prediction
   always @(posedge clock) begin
      out_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_seen++;
         if (stripped_text.size() == 0) begin
            mismatches++;
            $display("unexpected output byte %02h last %0b", rsp_out_byte, rsp_last);
         end else begin
            want = stripped_text.pop_front();
            if (rsp_out_byte !== want.text)
               report_mismatch("byte", rsp_out_byte, want.text);
            if (rsp_last !== want.last)
               report_mismatch("last", 8'(rsp_last), 8'(want.last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d predictions outstanding",
                  cycles, stripped_text.size());
         $display("c_comment_stripper_test failed");
         $finish;
      end
   end

   initial begin
      scanner_reset();
      // directed: every scanner mode but the backslash one, byte extremes, markers, pass-through
      add_text("a/*x*/ \"\\\"\" 'c'//q\\\n\n");
      add_byte(8'hff);
      add_text("\t(b)\n\n\n\n\n\n\n\n\n\n\n");
      add_text("#d m (p) x\n");
      add_eof();
      add_byte(CH_NUL);
      add_byte(8'hff);
      add_eof();
      // random text, ending each run with end of file
      while (total_items < RANDOM_ITEMS) add_fragment();
      add_eof();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_src.size() != 0 || req_valid || stripped_text.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d source bytes over %0d files, checked %0d output bytes",
               items_taken, files_ended, bytes_seen);
      $display("idling phases: none, sender, receiver, both; %0d mismatches", mismatches);
      if (mismatches == 0 && stripped_text.size() == 0) begin
         $display("c_comment_stripper_test passed");
      end else begin
         $display("c_comment_stripper_test failed");
      end
      $finish;
   end

endmodule
